// File: rtl/core/snpc_pkg.sv
// ----------------------------------------------------------------------------
// snpc_pkg
// Shared types, opcode constants and decode helpers for the next-PC unit.
// ----------------------------------------------------------------------------
package snpc_pkg;

	localparam int unsigned XLEN = 32;

	localparam logic [1:0] OP_BRANCH = 2'd0;
	localparam logic [1:0] OP_CALL   = 2'd1;
	localparam logic [1:0] OP_ARITH  = 2'd2;
	localparam logic [1:0] OP_MEMORY = 2'd3;

	localparam logic [2:0] OP2_BICC = 3'd2;
	localparam logic [5:0] OP3_JMPL = 6'd56;

	localparam logic [XLEN-1:0] INSN_BYTES = 32'd4;

	typedef enum logic [2:0] {
		COND_NEVER = 3'd0,
		COND_EQ    = 3'd1,
		COND_LE    = 3'd2,
		COND_LT    = 3'd3,
		COND_LEU   = 3'd4,
		COND_CS    = 3'd5,
		COND_NEG   = 3'd6,
		COND_VS    = 3'd7
	} cond_base_t;

	typedef struct packed {
		logic [XLEN-1:0] instruction;
		logic [XLEN-1:0] current_pc;
		logic [XLEN-1:0] next_pc;
		logic [XLEN-1:0] status_word;
	} in_word_t;

	typedef struct packed {
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
	} ops_t;

	function automatic logic [XLEN-1:0] reg_value(input logic [4:0] r);
		return {4{{3'b000, r}}};
	endfunction

	function automatic logic cond_true(input logic [3:0] cond, input logic [XLEN-1:0] psr);
		logic       n;
		logic       z;
		logic       v;
		logic       c;
		logic       base;
		cond_base_t sel;
		n    = psr[23];
		z    = psr[22];
		v    = psr[21];
		c    = psr[20];
		sel  = cond_base_t'(cond[2:0]);
		base = 1'b0;
		unique case (sel)
			COND_NEVER: base = 1'b0;
			COND_EQ:    base = z;
			COND_LE:    base = z | (n ^ v);
			COND_LT:    base = n ^ v;
			COND_LEU:   base = c | z;
			COND_CS:    base = c;
			COND_NEG:   base = n;
			COND_VS:    base = v;
			default:    base = 1'b0;
		endcase
		return cond[3] ? ~base : base;
	endfunction

endpackage

// File: rtl/core/snpc_if.sv
// ----------------------------------------------------------------------------
// snpc_if
// Valid/ready channels for the next-PC unit: instruction words in, results out.
// ----------------------------------------------------------------------------
interface snpc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;
	logic [31:0] current_pc;
	logic [31:0] next_pc;
	logic [31:0] status_word;

	modport source (output valid, output instruction, output current_pc,
		output next_pc, output status_word, input ready);
	modport sink (input valid, input instruction, input current_pc,
		input next_pc, input status_word, output ready);
endinterface

interface snpc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] following_pc;

	modport source (output valid, output following_pc, input ready);
	modport sink (input valid, input following_pc, output ready);
endinterface

// File: rtl/core/snpc_opsel.sv
// ----------------------------------------------------------------------------
// snpc_opsel
// Stage 2: decode the instruction word and register the two adder operands.
// ----------------------------------------------------------------------------
module snpc_opsel
	import snpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     up_valid,
	output logic     up_ready,
	input  in_word_t up_word,
	output logic     dn_valid,
	input  logic     dn_ready,
	output ops_t     dn_ops
);

	logic            valid_s2;
	ops_t            ops_s2;
	ops_t            ops_d;
	logic [XLEN-1:0] ir;
	logic [1:0]      op;

	assign ir       = up_word.instruction;
	assign op       = ir[31:30];
	assign up_ready = ~valid_s2 | dn_ready;
	assign dn_valid = valid_s2;
	assign dn_ops   = ops_s2;

	always_comb begin
		ops_d.a = up_word.next_pc;
		ops_d.b = INSN_BYTES;
		unique case (op)
			OP_CALL: begin
				ops_d.a = up_word.current_pc;
				ops_d.b = {ir[29:0], 2'b00};
			end
			OP_ARITH: begin
				if (ir[24:19] == OP3_JMPL) begin
					ops_d.a = reg_value(ir[18:14]);
					ops_d.b = ir[13] ? {{19{ir[12]}}, ir[12:0]} : reg_value(ir[4:0]);
				end
			end
			OP_BRANCH: begin
				if (ir[24:22] == OP2_BICC && cond_true(ir[28:25], up_word.status_word)) begin
					ops_d.a = up_word.current_pc;
					ops_d.b = {{8{ir[21]}}, ir[21:0], 2'b00};
				end
			end
			OP_MEMORY: begin
				ops_d.a = up_word.next_pc;
				ops_d.b = INSN_BYTES;
			end
			default: begin
				ops_d.a = up_word.next_pc;
				ops_d.b = INSN_BYTES;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			ops_s2 <= ops_d;
		end
	end

endmodule

// File: rtl/core/snpc_sum.sv
// ----------------------------------------------------------------------------
// snpc_sum
// Stage 3: add the operands modulo 2^32 and hold the result word for output.
// ----------------------------------------------------------------------------
module snpc_sum
	import snpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  ops_t              up_ops,
	snpc_out_if.source        result_ch
);

	logic            valid_s3;
	logic [XLEN-1:0] sum_s3;

	assign up_ready               = ~valid_s3 | result_ch.ready;
	assign result_ch.valid        = valid_s3;
	assign result_ch.following_pc = sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			sum_s3 <= up_ops.a + up_ops.b;
		end
	end

endmodule

// File: rtl/core/sparc_next_pc_unit_core.sv
// ----------------------------------------------------------------------------
// sparc_next_pc_unit_core
// Next-PC resolution for SPARC CALL, Bicc and JMPL in a three-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   instr_ch carries one word per item: instruction, current_pc, next_pc and
//   status_word (flags N, Z, V, C in bits 23..20). result_ch returns one word
//   per item, following_pc, in the order the items were taken.
//   Stage 1 registers the input word, stage 2 decodes the instruction and
//   selects the two operands, stage 3 adds them and holds the result.
//   A word taken on instr_ch passes the stage 1, stage 2 and stage 3 registers
//   in turn before it is presented on result_ch. Throughput: one word per cycle
//   while result_ch is ready.
//   Each stage takes a new word when it is empty or its contents move on, so
//   bubbles close up; when result_ch stalls, up to three words are held and
//   instr_ch.ready drops only once all stages are full.
//   Reset clears the stage valid bits; no result is presented after reset
//   until a word has been taken.
// ----------------------------------------------------------------------------
module sparc_next_pc_unit_core
	import snpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	snpc_in_if.sink    instr_ch,
	snpc_out_if.source result_ch
);

	logic     valid_s1;
	in_word_t word_s1;
	logic     ready_s2;
	logic     valid_s2;
	logic     ready_s3;
	ops_t     ops_s2;

	assign instr_ch.ready = ~valid_s1 | ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr_ch.ready) begin
			valid_s1 <= instr_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr_ch.valid && instr_ch.ready) begin
			word_s1.instruction <= instr_ch.instruction;
			word_s1.current_pc  <= instr_ch.current_pc;
			word_s1.next_pc     <= instr_ch.next_pc;
			word_s1.status_word <= instr_ch.status_word;
		end
	end

	snpc_opsel u_opsel (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s1),
		.up_ready (ready_s2),
		.up_word  (word_s1),
		.dn_valid (valid_s2),
		.dn_ready (ready_s3),
		.dn_ops   (ops_s2)
	);

	snpc_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (valid_s2),
		.up_ready  (ready_s3),
		.up_ops    (ops_s2),
		.result_ch (result_ch)
	);

	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		instr_ch.valid && instr_ch.ready |=> valid_s1)
		else $error("accepted word did not reach stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(word_s1))
		else $error("stage 1 lost or changed a stalled word");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.ready && !valid_s2 |=> !result_ch.valid)
		else $error("result repeated after draining");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!instr_ch.ready |-> valid_s1 && valid_s2 && result_ch.valid)
		else $error("input blocked while a stage is empty");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SPARC next-PC unit. A short table of hand-made
// words (CALL and branch offset extremes, annulled branches, JMPL with both
// operand forms, non-control words) is followed by random traffic that is
// weighted toward well-formed CALL, Bicc and JMPL words. Every result word is
// checked in order, against the table value for known rows and a predictor
// otherwise, through phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import snpc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_WORDS = 1052;
	localparam int unsigned NUM_PHASES   = 4;
	localparam int unsigned NUM_ROWS     = 24;

	localparam int unsigned PHASE_IDLE  [NUM_PHASES] = '{0, 78, 0, 21};
	localparam int unsigned PHASE_STALL [NUM_PHASES] = '{0, 0, 78, 21};

	typedef struct packed {
		logic       known;
		logic [31:0] golden;
		in_word_t    word;
	} row_t;

	// known, following_pc, instruction, current_pc, next_pc, status_word
	localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
		{1'b1, 32'h0000_1000, 32'h4000_0000, 32'h0000_1000, 32'h0000_1004, 32'h0000_0000},
		{1'b1, 32'hFFFF_FFFC, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0004, 32'h0000_0000},
		{1'b1, 32'h0000_2004, 32'h1080_0001, 32'h0000_2000, 32'h0000_2004, 32'h0000_0000},
		{1'b1, 32'h0000_3004, 32'h0080_0005, 32'h0000_2FFC, 32'h0000_3000, 32'hFFFF_FFFF},
		{1'b1, 32'h0080_0000, 32'h10A0_0000, 32'h0100_0000, 32'h0100_0004, 32'h0000_0000},
		{1'b1, 32'h007F_FFFC, 32'h109F_FFFF, 32'h0000_0000, 32'h0000_0004, 32'h0000_0000},
		{1'b1, 32'h0000_0108, 32'h3080_0002, 32'h0000_0100, 32'h0000_0104, 32'h0000_0000},
		{1'b1, 32'hFFFF_FFFF, 32'h81C0_3FFF, 32'h0000_0500, 32'h0000_0504, 32'h0000_0000},
		{1'b1, 32'h1F1F_2F1E, 32'h81C7_EFFF, 32'h0000_0500, 32'h0000_0504, 32'h0000_0000},
		{1'b1, 32'h3E3E_3E3E, 32'h81C7_C01F, 32'h0000_0500, 32'h0000_0504, 32'h0000_0000},
		{1'b1, 32'hFFFF_F000, 32'h81C0_3000, 32'h0000_0500, 32'h0000_0504, 32'h0000_0000},
		{1'b1, 32'h0000_0000, 32'h81C0_0000, 32'h0000_0500, 32'h0000_0504, 32'hFFFF_FFFF},
		{1'b1, 32'h0000_0000, 32'h81C8_0000, 32'hFFFF_FFF8, 32'hFFFF_FFFC, 32'h0000_0000},
		{1'b1, 32'h0000_0014, 32'hC000_0000, 32'h0000_000C, 32'h0000_0010, 32'h0000_0000},
		{1'b1, 32'h0000_0024, 32'h0100_0000, 32'h0000_001C, 32'h0000_0020, 32'h0000_0000},
		{1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFF8, 32'h7FFF_FFFC, 32'hFFFF_FFFF},
		{1'b0, 32'h0000_0000, 32'h0280_0004, 32'h0000_0400, 32'h0000_0404, 32'h0040_0000},
		{1'b0, 32'h0000_0000, 32'h0480_0010, 32'h0000_0400, 32'h0000_0404, 32'h0080_0000},
		{1'b0, 32'h0000_0000, 32'h0680_0010, 32'h0000_0400, 32'h0000_0404, 32'h00A0_0000},
		{1'b0, 32'h0000_0000, 32'h0880_0010, 32'h0000_0400, 32'h0000_0404, 32'h0010_0000},
		{1'b0, 32'h0000_0000, 32'h1A80_0010, 32'h0000_0400, 32'h0000_0404, 32'h0010_0000},
		{1'b0, 32'h0000_0000, 32'h1C80_0010, 32'h0000_0400, 32'h0000_0404, 32'hFF0F_FFFF},
		{1'b0, 32'h0000_0000, 32'h1E80_0010, 32'h0000_0400, 32'h0000_0404, 32'hFFFF_FFFF},
		{1'b0, 32'h0000_0000, 32'h0C80_0010, 32'h0000_0400, 32'h0000_0404, 32'h0080_0000}
	};

	logic clk;
	logic arst_n;

	snpc_in_if  in_ch ();
	snpc_out_if out_ch ();

	sparc_next_pc_unit_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.instr_ch  (in_ch),
		.result_ch (out_ch)
	);

	logic [31:0] following_pc_q [$];
	logic        drv_known;
	logic [31:0] drv_golden;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned n_call;
	int unsigned n_jmpl;
	int unsigned n_taken;
	int unsigned n_not_taken;
	int unsigned n_other;

	function automatic logic [31:0] reg_contents(input logic [4:0] r);
		return 32'(r) * 32'h0101_0101;
	endfunction

	function automatic logic branch_taken(input logic [3:0] cond, input logic [31:0] psr);
		logic hit;
		hit = 1'b0;
		case (cond_base_t'(cond[2:0]))
			COND_NEVER: hit = 1'b0;
			COND_EQ:    hit = psr[22];
			COND_LE:    hit = psr[22] | (psr[23] ^ psr[21]);
			COND_LT:    hit = psr[23] ^ psr[21];
			COND_LEU:   hit = psr[20] | psr[22];
			COND_CS:    hit = psr[20];
			COND_NEG:   hit = psr[23];
			COND_VS:    hit = psr[21];
			default:    hit = 1'b0;
		endcase
		return hit ^ cond[3];
	endfunction

	function automatic logic is_jmpl(input logic [31:0] insn);
		return insn[31:30] == OP_ARITH && insn[24:19] == OP3_JMPL;
	endfunction

	function automatic logic is_bicc(input logic [31:0] insn);
		return insn[31:30] == OP_BRANCH && insn[24:22] == OP2_BICC;
	endfunction

	function automatic logic [31:0] next_fetch_addr(input in_word_t w);
		logic [31:0] addr;
		logic [31:0] rhs;
		addr = w.next_pc + INSN_BYTES;
		if (w.instruction[31:30] == OP_CALL) begin
			addr = w.current_pc + {w.instruction[29:0], 2'b00};
		end else if (is_jmpl(w.instruction)) begin
			if (w.instruction[13])
				rhs = {{19{w.instruction[12]}}, w.instruction[12:0]};
			else
				rhs = reg_contents(w.instruction[4:0]);
			addr = reg_contents(w.instruction[18:14]) + rhs;
		end else if (is_bicc(w.instruction) &&
				branch_taken(w.instruction[28:25], w.status_word)) begin
			addr = w.current_pc + {{8{w.instruction[21]}}, w.instruction[21:0], 2'b00};
		end
		return addr;
	endfunction

	function automatic in_word_t rand_word();
		in_word_t    w;
		int unsigned pick;
		pick          = $urandom_range(99);
		w.instruction = $urandom;
		w.current_pc  = $urandom;
		w.next_pc     = $urandom_range(3) == 0 ? $urandom : w.current_pc + INSN_BYTES;
		w.status_word = $urandom_range(1) ? $urandom : ($urandom & 32'h00F0_0000);
		if (pick < 25) begin
			w.instruction[31:30] = OP_CALL;
		end else if (pick < 55) begin
			w.instruction[31:30] = OP_BRANCH;
			w.instruction[24:22] = OP2_BICC;
		end else if (pick < 80) begin
			w.instruction[31:30] = OP_ARITH;
			w.instruction[24:19] = OP3_JMPL;
		end
		return w;
	endfunction

	task automatic send_word(input in_word_t w, input logic known, input logic [31:0] golden);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.instruction = w.instruction;
		in_ch.current_pc  = w.current_pc;
		in_ch.next_pc     = w.next_pc;
		in_ch.status_word = w.status_word;
		drv_known         = known;
		drv_golden        = golden;
		in_ch.valid       = 1'b1;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (following_pc_q.size() != 0)
			@(negedge clk);
	endtask

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_ch.ready = $urandom_range(99) >= stall_pct;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** sparc_next_pc_unit_core: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin : monitor
		in_word_t    w;
		logic [31:0] want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (following_pc_q.size() == 0) begin
					$error("following_pc: expected none, actual %h", out_ch.following_pc);
					fail_count++;
				end else begin
					want = following_pc_q.pop_front();
					if (out_ch.following_pc !== want) begin
						$error("following_pc: expected %h, actual %h", want,
							out_ch.following_pc);
						fail_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				w.instruction = in_ch.instruction;
				w.current_pc  = in_ch.current_pc;
				w.next_pc     = in_ch.next_pc;
				w.status_word = in_ch.status_word;
				following_pc_q.push_back(drv_known ? drv_golden : next_fetch_addr(w));
				if (w.instruction[31:30] == OP_CALL)
					n_call++;
				else if (is_jmpl(w.instruction))
					n_jmpl++;
				else if (is_bicc(w.instruction) && branch_taken(w.instruction[28:25],
						w.status_word))
					n_taken++;
				else if (is_bicc(w.instruction))
					n_not_taken++;
				else
					n_other++;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.instruction = '0;
		in_ch.current_pc  = '0;
		in_ch.next_pc     = '0;
		in_ch.status_word = '0;
		out_ch.ready      = 1'b0;
		drv_known         = 1'b0;
		drv_golden        = '0;
		idle_pct          = 0;
		stall_pct         = 0;
		cycle_count       = 0;
		fail_count        = 0;
		n_call            = 0;
		n_jmpl            = 0;
		n_taken           = 0;
		n_not_taken       = 0;
		n_other           = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_pct  = PHASE_IDLE[p];
			stall_pct = PHASE_STALL[p];
			if (p == 0) begin
				for (int i = 0; i < NUM_ROWS; i++)
					send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].known,
						DIRECTED_ROWS[i].golden);
				// hold the sender until the pipeline is empty
				drain();
			end
			repeat (RANDOM_WORDS / NUM_PHASES)
				send_word(rand_word(), 1'b0, '0);
			drain();
		end

		repeat (8) @(negedge clk);
		if (following_pc_q.size() != 0) begin
			$error("following_pc: expected %0d more words, actual 0", following_pc_q.size());
			fail_count++;
		end
		$display("Resolved %0d CALL, %0d JMPL, %0d taken and %0d untaken Bicc, %0d other words.",
			n_call, n_jmpl, n_taken, n_not_taken, n_other);
		$display("Traffic ran free, with sender gaps, with result stalls and with both mixed.");
		if (fail_count == 0)
			$display("** sparc_next_pc_unit_core: PASSED **");
		else
			$display("** sparc_next_pc_unit_core: FAILED **");
		$finish;
	end

endmodule
